/* hw/rtl/vtpd_pkg.sv */
// Package for the vertex transform with perspective divide.
// Holds payload structs, widths, register indexes and the queue entry type.
// Depends on nothing.
package vtpd_pkg;

	localparam int CoordWidth = 32;
	localparam int FracBits   = 16;
	localparam int NumRegs    = 8;
	localparam int RegWidth   = 64;
	localparam int IdxWidth   = 3;
	// Accumulator: product 64 bits plus growth for four terms.
	localparam int AccWidth   = 2 * CoordWidth + 2;
	// Dividend magnitude width (|acc| shifted by the fraction bits).
	localparam int NumWidth   = AccWidth + FracBits;
	localparam int DenWidth   = AccWidth;
	localparam int QWidth     = NumWidth;

	typedef struct packed {
		logic signed [31:0] in_z;
		logic signed [31:0] in_y;
		logic signed [31:0] in_x;
	} in_item_t;

	typedef struct packed {
		logic               w_was_zero;
		logic signed [31:0] out_z;
		logic signed [31:0] out_y;
		logic signed [31:0] out_x;
	} out_item_t;

	// One classified item on its way from the front to the back part.
	typedef struct packed {
		logic                       wzero;
		logic [2:0]                 neg;
		logic [2:0][NumWidth-1:0]   num;
		logic [DenWidth-1:0]        den;
	} job_t;

	localparam logic [IdxWidth-1:0] RegRow0Cols01 = 3'd0;
	localparam logic [IdxWidth-1:0] RegRow0Cols23 = 3'd1;
	localparam logic [IdxWidth-1:0] RegRow1Cols01 = 3'd2;
	localparam logic [IdxWidth-1:0] RegRow1Cols23 = 3'd3;
	localparam logic [IdxWidth-1:0] RegRow2Cols01 = 3'd4;
	localparam logic [IdxWidth-1:0] RegRow2Cols23 = 3'd5;
	localparam logic [IdxWidth-1:0] RegRow3Cols01 = 3'd6;
	localparam logic [IdxWidth-1:0] RegRow3Cols23 = 3'd7;

	localparam logic [RegWidth-1:0] One = 64'd65536;
	localparam logic [RegWidth-1:0] OneHi = 64'd281474976710656;

	// Saturate a sign and magnitude to the signed coordinate range.
	function automatic logic [31:0] sat(input logic neg, input logic [QWidth-1:0] mag);
		logic [QWidth-1:0] lim;
		logic [QWidth-1:0] v;
		lim = QWidth'(1) << (CoordWidth - 1);
		if (neg) begin
			v = (mag > lim) ? lim : mag;
			v = QWidth'(0) - v;
		end else begin
			v = (mag > lim - QWidth'(1)) ? lim - QWidth'(1) : mag;
		end
		sat = v[31:0];
	endfunction

endpackage

/* hw/rtl/vtpd_front.sv */
// Front part: matrix registers, multiply stage, sum stage and classification.
// Uses vtpd_pkg. Three pipeline stages with a valid bit each; stalls as a whole.
module vtpd_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [vtpd_pkg::IdxWidth-1:0]        cfg_index,
	input  logic [vtpd_pkg::RegWidth-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  vtpd_pkg::in_item_t                   in_data,
	output logic                                 job_valid,
	input  logic                                 job_ready,
	output vtpd_pkg::job_t                       job
);

	logic [vtpd_pkg::RegWidth-1:0] regs_q [vtpd_pkg::NumRegs];
	logic                          v_s1, v_s2, v_s3;
	logic signed [63:0]            prod_s1 [4][3];
	logic signed [63:0]            tr_s1 [4];
	logic signed [vtpd_pkg::AccWidth-1:0] acc_s2 [4];
	vtpd_pkg::job_t                job_s3;
	logic                          adv;

	// Configuration registers, identity after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[vtpd_pkg::RegRow0Cols01] <= vtpd_pkg::One;
			regs_q[vtpd_pkg::RegRow0Cols23] <= '0;
			regs_q[vtpd_pkg::RegRow1Cols01] <= vtpd_pkg::OneHi;
			regs_q[vtpd_pkg::RegRow1Cols23] <= '0;
			regs_q[vtpd_pkg::RegRow2Cols01] <= '0;
			regs_q[vtpd_pkg::RegRow2Cols23] <= vtpd_pkg::One;
			regs_q[vtpd_pkg::RegRow3Cols01] <= '0;
			regs_q[vtpd_pkg::RegRow3Cols23] <= vtpd_pkg::OneHi;
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	function automatic logic signed [31:0] elem(input logic [vtpd_pkg::RegWidth-1:0] r,
		input logic hi);
		elem = hi ? r[63:32] : r[31:0];
	endfunction

	// The whole pipeline moves unless its last stage is full and blocked.
	assign adv      = !v_s3 || job_ready;
	assign in_ready = adv;
	assign job_valid = v_s3;
	assign job       = job_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: twelve 32x32 products and the scaled translation row.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[c][0] <= 64'(in_data.in_x) *
					64'(elem(regs_q[{2'd0, c[1]}], c[0]));
				prod_s1[c][1] <= 64'(in_data.in_y) *
					64'(elem(regs_q[{2'd1, c[1]}], c[0]));
				prod_s1[c][2] <= 64'(in_data.in_z) *
					64'(elem(regs_q[{2'd2, c[1]}], c[0]));
				tr_s1[c] <= 64'(elem(regs_q[{2'd3, c[1]}], c[0])) <<<
					vtpd_pkg::FracBits;
			end
		end
	end

	// Stage 2: four-term sums, kept exact.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				acc_s2[c] <= vtpd_pkg::AccWidth'(tr_s1[c]) +
					vtpd_pkg::AccWidth'(prod_s1[c][0]) +
					vtpd_pkg::AccWidth'(prod_s1[c][1]) +
					vtpd_pkg::AccWidth'(prod_s1[c][2]);
			end
		end
	end

	// Stage 3: classify on w and form sign and magnitude operands.
	always_ff @(posedge clk) begin
		if (adv) begin
			logic wz;
			logic wn;
			logic [vtpd_pkg::AccWidth-1:0] mag;
			logic signed [vtpd_pkg::AccWidth-1:0] fl;
			wz = (acc_s2[3] == '0);
			wn = acc_s2[3][vtpd_pkg::AccWidth-1];
			job_s3.wzero <= wz;
			job_s3.den <= wn ? -acc_s2[3] : acc_s2[3];
			for (int c = 0; c < 3; c++) begin
				if (wz) begin
					fl  = acc_s2[c] >>> vtpd_pkg::FracBits;
					mag = fl[vtpd_pkg::AccWidth-1] ? -fl : fl;
					job_s3.neg[c] <= fl[vtpd_pkg::AccWidth-1];
					job_s3.num[c] <= vtpd_pkg::NumWidth'(mag);
				end else begin
					mag = acc_s2[c][vtpd_pkg::AccWidth-1] ? -acc_s2[c] : acc_s2[c];
					job_s3.neg[c] <= acc_s2[c][vtpd_pkg::AccWidth-1] ^ wn;
					job_s3.num[c] <= vtpd_pkg::NumWidth'(mag) << vtpd_pkg::FracBits;
				end
			end
		end
	end

endmodule

/* hw/rtl/vtpd_queue.sv */
// Short two-entry queue between the front and back parts.
// Uses vtpd_pkg for the job type.
module vtpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  vtpd_pkg::job_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output vtpd_pkg::job_t rd_data
);

	vtpd_pkg::job_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

/* hw/rtl/vtpd_back.sv */
// Back part: pipelined restoring divider, one quotient bit per stage, three lanes.
// Uses vtpd_pkg. Ends in the output register; the pipeline stalls as a whole.
module vtpd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  vtpd_pkg::job_t        job,
	output logic                  out_valid,
	input  logic                  out_ready,
	output vtpd_pkg::out_item_t   out_data
);

	localparam int N = vtpd_pkg::QWidth;
	localparam int R = vtpd_pkg::DenWidth + 1;

	logic                         v_q   [N+1];
	logic                         wz_q  [N+1];
	logic [2:0]                   neg_q [N+1];
	logic [vtpd_pkg::DenWidth-1:0] den_q [N+1];
	logic [2:0][N-1:0]            num_q [N+1];
	logic [2:0][R-1:0]            rem_q [N+1];
	logic [2:0][N-1:0]            quo_q [N+1];
	logic                         ov_q;
	vtpd_pkg::out_item_t          od_q;
	logic                         adv;

	assign adv       = !ov_q || out_ready;
	assign job_ready = adv;
	assign out_valid = ov_q;
	assign out_data  = od_q;

	// Stage 0 loads the job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= N; s++) v_q[s] <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_q[0] <= job_valid;
			for (int s = 1; s <= N; s++) v_q[s] <= v_q[s-1];
			ov_q <= v_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wz_q[0]  <= job.wzero;
			neg_q[0] <= job.neg;
			den_q[0] <= job.den;
			num_q[0] <= job.num;
			rem_q[0] <= '0;
			quo_q[0] <= '0;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar s = 0; s < N; s++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				logic [R-1:0] tr;
				wz_q[s+1]  <= wz_q[s];
				neg_q[s+1] <= neg_q[s];
				den_q[s+1] <= den_q[s];
				num_q[s+1] <= num_q[s];
				for (int l = 0; l < 3; l++) begin
					tr = {rem_q[s][l][R-2:0], num_q[s][l][N-1-s]};
					if (tr >= R'(den_q[s])) begin
						rem_q[s+1][l] <= tr - R'(den_q[s]);
						quo_q[s+1][l] <= quo_q[s][l] | (N'(1) << (N-1-s));
					end else begin
						rem_q[s+1][l] <= tr;
						quo_q[s+1][l] <= quo_q[s][l];
					end
				end
			end
		end
	end

	// Output register: saturated quotient, or saturated floor when w is zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			od_q.out_x <= vtpd_pkg::sat(neg_q[N][0], wz_q[N] ? num_q[N][0] : quo_q[N][0]);
			od_q.out_y <= vtpd_pkg::sat(neg_q[N][1], wz_q[N] ? num_q[N][1] : quo_q[N][1]);
			od_q.out_z <= vtpd_pkg::sat(neg_q[N][2], wz_q[N] ? num_q[N][2] : quo_q[N][2]);
			od_q.w_was_zero <= wz_q[N];
		end
	end

endmodule

/* hw/rtl/vertex_transform_perspective_divide.sv */
// Top level of the vertex transform with perspective divide.
// Uses vtpd_pkg, vtpd_front, vtpd_queue and vtpd_back.
//
// Usage: write the eight matrix registers through cfg_we, cfg_index and
// cfg_data (row r, columns 0/1 or 2/3; low half is the even column) while
// the block is idle. Points enter on in_valid/in_ready as in_data (Q16.16
// x, y, z); results leave on out_valid/out_ready as out_data with the
// divided point and a flag set when w was zero.
// Throughput: one item per cycle while the receiver accepts results. An item
// passes 3 front stages, the queue, 83 divider stages (a load stage and the
// bit-per-stage divider over the 82-bit dividend) and the output register.
// Reset loads the identity matrix and empties every stage and the queue.
// When the receiver stalls, the back pipeline holds, the queue fills and
// then the front holds and drops in_ready; no item is lost.
module vertex_transform_perspective_divide (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vtpd_pkg::IdxWidth-1:0]  cfg_index,
	input  logic [vtpd_pkg::RegWidth-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  vtpd_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output vtpd_pkg::out_item_t            out_data
);

	logic           fq_valid, fq_ready, qb_valid, qb_ready;
	vtpd_pkg::job_t fq_job, qb_job;

	vtpd_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .in_data,
		.job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
	);

	vtpd_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
	);

	vtpd_back u_back (
		.clk, .arst_n,
		.job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
		.out_valid, .out_ready, .out_data
	);

endmodule

/* dv/tb_vertex_transform_perspective_divide.sv */
// Testbench for the vertex transform with perspective divide.
// Drives points through a configured 4x4 matrix and checks every result.
// Depends on vtpd_pkg and the vertex_transform_perspective_divide top level.
module tb_vertex_transform_perspective_divide;

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles   = 120;

	// Matrix shadow, row-major per register.
	logic [63:0] matrix_regs [vtpd_pkg::NumRegs];

	// Bit-exact model of one transformed point.
	function automatic vtpd_pkg::out_item_t transform_point(vtpd_pkg::in_item_t pt);
		logic signed [127:0] acc [4];
		logic signed [127:0] pv [3];
		logic signed [127:0] elem;
		logic [127:0] mag;
		logic [127:0] den;
		logic [127:0] q;
		logic [127:0] lim;
		logic [31:0] res [3];
		logic neg;
		logic wz;
		logic [63:0] r;
		vtpd_pkg::out_item_t o;
		pv[0] = 128'(signed'(pt.in_x));
		pv[1] = 128'(signed'(pt.in_y));
		pv[2] = 128'(signed'(pt.in_z));
		lim = 128'(1) << 31;
		for (int c = 0; c < 4; c++) begin
			r = matrix_regs[6 + c / 2];
			elem = (c % 2) ? 128'(signed'(r[63:32])) : 128'(signed'(r[31:0]));
			acc[c] = elem <<< vtpd_pkg::FracBits;
			for (int k = 0; k < 3; k++) begin
				r = matrix_regs[2 * k + c / 2];
				elem = (c % 2) ? 128'(signed'(r[63:32])) : 128'(signed'(r[31:0]));
				acc[c] = acc[c] + pv[k] * elem;
			end
		end
		wz = (acc[3] == 0);
		den = acc[3][127] ? -acc[3] : acc[3];
		for (int c = 0; c < 3; c++) begin
			if (wz) begin
				q = acc[c] >>> vtpd_pkg::FracBits;
				neg = q[127];
				mag = neg ? -q : q;
			end else begin
				neg = acc[c][127] != acc[3][127];
				mag = acc[c][127] ? -acc[c] : acc[c];
				mag = (mag << vtpd_pkg::FracBits) / den;
			end
			// Clamp the magnitude to the signed 32-bit range.
			if (neg) res[c] = (mag > lim) ? lim[31:0] : 32'(-mag);
			else res[c] = (mag > lim - 1) ? 32'h7fff_ffff : mag[31:0];
			if (neg && mag > lim) res[c] = 32'h8000_0000;
		end
		o.out_x = res[0];
		o.out_y = res[1];
		o.out_z = res[2];
		o.w_was_zero = wz;
		return o;
	endfunction

	// Holds expected results in arrival order.
	class point_scoreboard;
		vtpd_pkg::out_item_t pending_points[$];
		int errors;

		function void note_point(vtpd_pkg::in_item_t pt);
			pending_points.push_back(transform_point(pt));
		endfunction

		function void check_point(vtpd_pkg::out_item_t got);
			vtpd_pkg::out_item_t exp_pt;
			if (pending_points.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
				return;
			end
			exp_pt = pending_points.pop_front();
			if (got.out_x !== exp_pt.out_x) begin
				$error("out_x expected %h actual %h", exp_pt.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== exp_pt.out_y) begin
				$error("out_y expected %h actual %h", exp_pt.out_y, got.out_y);
				errors++;
			end
			if (got.out_z !== exp_pt.out_z) begin
				$error("out_z expected %h actual %h", exp_pt.out_z, got.out_z);
				errors++;
			end
			if (got.w_was_zero !== exp_pt.w_was_zero) begin
				$error("w_was_zero expected %b actual %b", exp_pt.w_was_zero,
					got.w_was_zero);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [vtpd_pkg::IdxWidth-1:0] cfg_index;
	logic [vtpd_pkg::RegWidth-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	vtpd_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	vtpd_pkg::out_item_t out_data;

	point_scoreboard sb;
	int idle_cycles;

	vertex_transform_perspective_divide uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sample both channels at the rising edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if (in_valid && in_ready) sb.note_point(in_data);
			if (out_valid && out_ready) sb.check_point(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("[vertex_transform_perspective_divide] ERROR");
				$finish;
			end
		end
	end

	// Receiver stalls a random number of cycles before each result.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic write_reg(input logic [vtpd_pkg::IdxWidth-1:0] idx,
		input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		matrix_regs[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Valid stays high from one item to the next unless an idle gap is drawn.
	task automatic send_point(input vtpd_pkg::in_item_t pt, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= pt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Wait for every result, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_points.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(signed'($urandom_range(0, 2 ** 20)) - 2 ** 19);
			3: return 32'($urandom_range(0, 8)) << 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] rand_reg();
		return {rand_coord(), rand_coord()};
	endfunction

	task automatic random_matrix(input int style);
		for (int i = 0; i < vtpd_pkg::NumRegs; i++) begin
			case (style)
				0: write_reg(i[vtpd_pkg::IdxWidth-1:0], rand_reg());
				1: write_reg(i[vtpd_pkg::IdxWidth-1:0], {$urandom, $urandom});
				// Projection-like: w column small, so divides are typical.
				default: write_reg(i[vtpd_pkg::IdxWidth-1:0],
					(i[vtpd_pkg::IdxWidth-1:0] inside {vtpd_pkg::RegRow0Cols23,
					vtpd_pkg::RegRow1Cols23, vtpd_pkg::RegRow2Cols23}) ?
					{32'($urandom_range(0, 3)) << 15, rand_coord()} : rand_reg());
			endcase
		end
	endtask

	initial begin
		vtpd_pkg::in_item_t pt;
		logic [31:0] edges [4];
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		matrix_regs[vtpd_pkg::RegRow0Cols01] = vtpd_pkg::One;
		matrix_regs[vtpd_pkg::RegRow0Cols23] = 64'd0;
		matrix_regs[vtpd_pkg::RegRow1Cols01] = vtpd_pkg::OneHi;
		matrix_regs[vtpd_pkg::RegRow1Cols23] = 64'd0;
		matrix_regs[vtpd_pkg::RegRow2Cols01] = 64'd0;
		matrix_regs[vtpd_pkg::RegRow2Cols23] = vtpd_pkg::One;
		matrix_regs[vtpd_pkg::RegRow3Cols01] = 64'd0;
		matrix_regs[vtpd_pkg::RegRow3Cols23] = vtpd_pkg::OneHi;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Identity after reset, with coordinate extremes.
		edges[0] = 32'h8000_0000;
		edges[1] = 32'h7fff_ffff;
		edges[2] = 32'h0;
		edges[3] = 32'hffff_ffff;
		for (int i = 0; i < 12; i++) begin
			pt.in_x = edges[i % 4];
			pt.in_y = edges[(i / 4) % 4];
			pt.in_z = edges[(i + 1) % 4];
			send_point(pt, i < 6);
		end
		drain();

		// Zero w column: divide skipped, flag raised, large sums saturate.
		write_reg(vtpd_pkg::RegRow3Cols23, 64'd0);
		write_reg(vtpd_pkg::RegRow0Cols01, 64'h7fff_ffff_7fff_ffff);
		for (int i = 0; i < 6; i++) begin
			pt.in_x = edges[i % 4];
			pt.in_y = edges[(i + 2) % 4];
			pt.in_z = rand_coord();
			send_point(pt, 1'b0);
		end
		drain();

		// Tiny w with extremes forces divide saturation.
		random_matrix(0);
		write_reg(vtpd_pkg::RegRow3Cols23, {32'h0000_0001, 32'h8000_0000});
		write_reg(vtpd_pkg::RegRow0Cols23, {32'h0, 32'h7fff_ffff});
		write_reg(vtpd_pkg::RegRow1Cols23, {32'h0, 32'h8000_0000});
		write_reg(vtpd_pkg::RegRow2Cols23, {32'h0, 32'h0});
		for (int i = 0; i < 6; i++) begin
			pt.in_x = edges[i % 4];
			pt.in_y = edges[(i + 1) % 4];
			pt.in_z = edges[(i + 3) % 4];
			send_point(pt, 1'b0);
		end
		drain();

		// Random phases, each with a fresh matrix.
		for (int ph = 0; ph < 9; ph++) begin
			random_matrix(ph % 3);
			for (int i = 0; i < 100; i++) begin
				pt.in_x = rand_coord();
				pt.in_y = rand_coord();
				pt.in_z = rand_coord();
				send_point(pt, (ph % 4) == 3);
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("[vertex_transform_perspective_divide] OK");
		end else begin
			$display("[vertex_transform_perspective_divide] ERROR");
		end
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/vtpd_pkg.sv
hw/rtl/vtpd_front.sv
hw/rtl/vtpd_queue.sv
hw/rtl/vtpd_back.sv
hw/rtl/vertex_transform_perspective_divide.sv
dv/tb_vertex_transform_perspective_divide.sv
